// ===== sv/lisbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisbs_pkg
// Shared constants and control/status types for the streaming LIS length
// block: table depth, derived widths and controller/datapath structs.
// ----------------------------------------------------------------------------
package lisbs_pkg;

  // Depth of the smallest-tail table
  localparam int unsigned MaxLength = 1024;

  // Widths derived from the table depth
  localparam int unsigned AddrW = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int unsigned RunW  = $clog2(MaxLength + 1);

  // Fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 11;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // input beat accepted: load value, open search window
    logic probe;   // fold the registered tail compare into the window
    logic commit;  // write the table, update length, load result register
  } lisbs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search_done;  // search window is empty
    logic out_free;     // result register can take a new beat
  } lisbs_sts_t;

endpackage

// ===== sv/lisbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisbs_ctrl
// Controller: accepts one input beat at a time, runs the binary search
// until the window closes, then commits once the result register is free.
// ----------------------------------------------------------------------------
module lisbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lisbs_pkg::lisbs_sts_t sts_i,
  output lisbs_pkg::lisbs_cmd_t cmd_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StSearch = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StSearch;
        end
      end
      StSearch: begin
        if (!sts_i.search_done) begin
          cmd_o.probe = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/lisbs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisbs_dp
// Datapath: tail table memory, search window, run length, overflow flag
// and the output result register.
// ----------------------------------------------------------------------------
module lisbs_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [lisbs_pkg::ValueW-1:0] value_i,
  input  logic                              last_i,
  input  lisbs_pkg::lisbs_cmd_t             cmd_i,
  output lisbs_pkg::lisbs_sts_t             sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lisbs_pkg::LenW-1:0]        lis_length_o,
  output logic                              overflow_o,
  output logic                              last_out_o
);

  // Tail table, undefined until written
  logic signed [lisbs_pkg::ValueW-1:0] mem [lisbs_pkg::MaxLength];

  logic signed [lisbs_pkg::ValueW-1:0] value_q;
  logic signed [lisbs_pkg::ValueW-1:0] rd_q;
  logic                                last_q;
  logic [lisbs_pkg::RunW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [lisbs_pkg::RunW-1:0]          run_q, run_new;
  logic                                ovf_q, ovf_new;
  logic                                pos_lt, can_app, wr_en;
  logic                                out_valid_q, out_valid_d;
  logic [lisbs_pkg::LenW-1:0]          out_len_q;
  logic                                out_ovf_q, out_last_q;

  // Open the search window on start and narrow it on each probe
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = run_q;
    end else if (cmd_i.probe) begin
      if (rd_q >= value_q) begin
        hi_d = mid_q;
      end else begin
        lo_d = mid_q + lisbs_pkg::RunW'(1);
      end
    end
    mid_d = lo_d + ((hi_d - lo_d) >> 1);
  end

  // Decide replace, append or overflow
  always_comb begin
    pos_lt  = (lo_q < run_q);
    can_app = (run_q < lisbs_pkg::RunW'(lisbs_pkg::MaxLength));
    wr_en   = cmd_i.commit && (pos_lt || can_app);
    run_new = (!pos_lt && can_app) ? run_q + lisbs_pkg::RunW'(1) : run_q;
    ovf_new = ovf_q | (!pos_lt && !can_app);
  end

  // Table write and registered probe read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[lo_q[lisbs_pkg::AddrW-1:0]] <= value_q;
    end
    rd_q <= mem[mid_d[lisbs_pkg::AddrW-1:0]];
  end

  // Hold the item under search and register the probe midpoint
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
    mid_q <= mid_d;
  end

  // Window, run length and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      run_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      if (cmd_i.commit) begin
        run_q <= last_q ? '0 : run_new;
        ovf_q <= last_q ? 1'b0 : ovf_new;
      end
    end
  end

  // Result register: load on commit, drop on output beat
  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_len_q  <= lisbs_pkg::LenW'(run_new);
      out_ovf_q  <= ovf_new;
      out_last_q <= last_q;
    end
  end

  assign sts_o.search_done = (lo_q == hi_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign lis_length_o = out_len_q;
  assign overflow_o   = out_ovf_q;
  assign last_out_o   = out_last_q;

endmodule

// ===== sv/lis_length_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_length_binary_search
// Streaming longest strictly increasing subsequence length. Keeps a table
// of smallest tails, binary-searches each value into it and returns the
// running length per item; an item marked last restarts the sequence.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   value_i, last_i
//   out      output     out_valid_o / out_ready_i lis_length_o, overflow_o,
//                                                 last_out_o
//
// Steps: an item is accepted, then searched with one probe of the single read
// port of the tail table per cycle until the window is empty, then committed
// in a commit step that writes the table unless it overflows.
// Reset clears the length, overflow flag and handshake state; the table
// itself is not cleared and needs no clearing pass.
// A new input beat is taken while the previous result waits on out; the
// commit stalls only while that earlier result is still unaccepted.
// ----------------------------------------------------------------------------
module lis_length_binary_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lisbs_pkg::ValueW-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lisbs_pkg::LenW-1:0]        lis_length_o,
  output logic                              overflow_o,
  output logic                              last_out_o
);

  lisbs_pkg::lisbs_cmd_t cmd;
  lisbs_pkg::lisbs_sts_t sts;

  lisbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lisbs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lis_length_o (lis_length_o),
    .overflow_o   (overflow_o),
    .last_out_o   (last_out_o)
  );

endmodule

// ===== sv/lisbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisbs_checker
// Port-level checks on the LIS length block, attached by bind.
// ----------------------------------------------------------------------------
module lisbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [lisbs_pkg::LenW-1:0] lis_length_o,
  input logic                       overflow_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Every result counts at least the current value
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lis_length_o != '0)
    else $error("zero length reported");

  // Overflow only with a saturated length
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      lis_length_o == lisbs_pkg::LenW'(lisbs_pkg::MaxLength))
    else $error("overflow without saturated length");

  // One item at a time: no input beat right after an accepted one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while search in flight");

endmodule

bind lis_length_binary_search lisbs_checker u_lisbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .lis_length_o (lis_length_o),
  .overflow_o   (overflow_o)
);
